@@ design/wuf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the weighted union-find engine.
// No dependencies; imported by every module of the block except wuf_checker.
package wuf_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One forest entry: subtree size and parent link.
  typedef struct packed {
    cnt_t size;
    idx_t parent;
  } node_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    node_t wdata;
    idx_t  raddr;
  } ram_req_t;

  typedef struct packed {
    logic restart;
    cnt_t count;
  } cfg_t;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_UNION = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_ELEMENT_COUNT = 1'b0;

endpackage

@@ design/wuf_forest_ram.sv @@
`timescale 1ns / 1ps
// Forest memory with one write port and one registered read port, holding
// parent link and size per element. Depends on wuf_pkg for the entry and request types.
module wuf_forest_ram
  import wuf_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output node_t    rd
);

  node_t mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd <= mem[req.raddr];
  end

endmodule

@@ design/wuf_cfg_regs.sv @@
`timescale 1ns / 1ps
// APB register file: the element_count register and its restart pulse.
// Depends on wuf_pkg.
module wuf_cfg_regs
  import wuf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cnt_t element_count;
  cnt_t wr_value;
  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);

  always_comb begin
    wr_value = pwdata[CNT_W-1:0];
    if (wr_value == '0) begin
      wr_value = cnt_t'(1);
    end else if (wr_value > cnt_t'(MAX_ELEMENTS)) begin
      wr_value = cnt_t'(MAX_ELEMENTS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= cnt_t'(MAX_ELEMENTS);
    end else if (wr_hit) begin
      element_count <= wr_value;
    end
  end

  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {{(32-CNT_W){1'b0}}, element_count} : '0;

  assign cfg.restart = wr_hit;
  assign cfg.count   = element_count;

endmodule

@@ design/wuf_sequencer.sv @@
`timescale 1ns / 1ps
// Sequencer for the union-find engine: forest clearing, root walks, linking.
// Depends on wuf_pkg; drives the request port of wuf_forest_ram.
module wuf_sequencer
  import wuf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     start,
  output logic     busy,
  input  logic     operation,
  input  idx_t     index_p,
  input  idx_t     index_q,
  output logic     done,
  output idx_t     root_p,
  output idx_t     root_q,
  output logic     same_set,
  output logic     merged,
  output cnt_t     component_count,
  output logic     index_error,
  output ram_req_t req,
  input  node_t    rd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WALK_P = 7'b0000100,
    S_WALK_Q = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_GROW   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  idx_t   clr_addr;
  idx_t   cur;
  logic   op_reg;
  idx_t   q_reg;
  logic   err_reg;
  idx_t   rp_reg;
  idx_t   rq_reg;
  cnt_t   size_p;
  cnt_t   size_q;
  idx_t   big_root;
  cnt_t   size_sum;
  logic   merge_reg;
  cnt_t   sets_left;

  logic   out_of_range;
  logic   do_merge;
  logic   p_under;
  logic   at_root;

  assign busy         = (state != S_IDLE);
  assign out_of_range = ({1'b0, index_p} >= cfg.count) || ({1'b0, index_q} >= cfg.count);
  assign at_root      = (rd.parent == cur);
  assign do_merge     = (op_reg == OP_UNION) && (rp_reg != rq_reg);
  // Smaller tree goes under the larger; on a tie the q root goes under p.
  assign p_under      = (size_p < size_q);

  always_comb begin
    req.we    = 1'b0;
    req.waddr = clr_addr;
    req.wdata = '0;
    req.raddr = cur;
    case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.wdata = '{size: cnt_t'(1), parent: clr_addr};
      end
      S_IDLE: begin
        req.raddr = index_p;
      end
      S_WALK_P: begin
        req.raddr = at_root ? q_reg : rd.parent;
      end
      S_WALK_Q: begin
        req.raddr = rd.parent;
      end
      S_LINK: begin
        req.we = do_merge;
        if (p_under) begin
          req.waddr = rp_reg;
          req.wdata = '{size: size_p, parent: rq_reg};
        end else begin
          req.waddr = rq_reg;
          req.wdata = '{size: size_q, parent: rp_reg};
        end
      end
      S_GROW: begin
        req.we    = 1'b1;
        req.waddr = big_root;
        req.wdata = '{size: size_sum, parent: big_root};
      end
      default: begin
        req.we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg.restart) begin
        state    <= S_CLEAR;
        clr_addr <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + idx_t'(1);
            if (clr_addr == idx_t'(MAX_ELEMENTS - 1)) begin
              sets_left <= cfg.count;
              state     <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (start) begin
              op_reg  <= operation;
              q_reg   <= index_q;
              cur     <= index_p;
              err_reg <= out_of_range;
              state   <= out_of_range ? S_FINISH : S_WALK_P;
            end
          end
          S_WALK_P: begin
            if (at_root) begin
              rp_reg <= cur;
              size_p <= rd.size;
              cur    <= q_reg;
              state  <= S_WALK_Q;
            end else begin
              cur <= rd.parent;
            end
          end
          S_WALK_Q: begin
            if (at_root) begin
              rq_reg <= cur;
              size_q <= rd.size;
              state  <= S_LINK;
            end else begin
              cur <= rd.parent;
            end
          end
          S_LINK: begin
            merge_reg <= do_merge;
            big_root  <= p_under ? rq_reg : rp_reg;
            size_sum  <= size_p + size_q;
            if (do_merge) begin
              if (sets_left != '0) begin
                sets_left <= sets_left - cnt_t'(1);
              end
              state <= S_GROW;
            end else begin
              state <= S_FINISH;
            end
          end
          S_GROW: begin
            state <= S_FINISH;
          end
          S_FINISH: begin
            done            <= 1'b1;
            index_error     <= err_reg;
            root_p          <= err_reg ? '0 : rp_reg;
            root_q          <= err_reg ? '0 : rq_reg;
            same_set        <= err_reg ? 1'b0 : (rp_reg == rq_reg);
            merged          <= err_reg ? 1'b0 : merge_reg;
            component_count <= sets_left;
            state           <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

@@ design/weighted_union_find.sv @@
`timescale 1ns / 1ps
// Top level of the weighted quick-union disjoint-set engine.
// Depends on wuf_pkg, wuf_cfg_regs, wuf_sequencer and wuf_forest_ram.
//
// An item is taken when start is high while busy is low. The forest lives in
// one memory with a registered read port and a separate write port, and the
// root walks follow one parent link per cycle. An item passes through the walk
// of p, the walk of q and the link step, then a grow step when a union merges
// two sets, and ends in a finish step. With union by size a tree of n elements
// is at most log2(n) links deep, and in a merging union the smaller tree holds
// at most 512 elements. An item with an index not below element_count skips
// the walks and is reported with index_error set. Each result appears for
// exactly one cycle with done high, in the same cycle that busy falls, and
// cannot be held off. After reset, and after every write of element_count, the
// engine clears all 1024 entries of its forest with busy high.
module weighted_union_find
  import wuf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [9:0]  index_p,
  input  logic [9:0]  index_q,
  output logic        done,
  output logic [9:0]  root_p,
  output logic [9:0]  root_q,
  output logic        same_set,
  output logic        merged,
  output logic [10:0] component_count,
  output logic        index_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  ram_req_t req;
  node_t    rd;

  wuf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wuf_sequencer u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .index_p         (index_p),
    .index_q         (index_q),
    .done            (done),
    .root_p          (root_p),
    .root_q          (root_q),
    .same_set        (same_set),
    .merged          (merged),
    .component_count (component_count),
    .index_error     (index_error),
    .req             (req),
    .rd              (rd)
  );

  wuf_forest_ram u_ram (
    .clk (clk),
    .req (req),
    .rd  (rd)
  );

endmodule

@@ design/wuf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the union-find engine, bound to the top level.
// Depends only on the ports of weighted_union_find.
module wuf_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [9:0]  root_p,
  input logic [9:0]  root_q,
  input logic        same_set,
  input logic        merged,
  input logic        index_error
);

  // Every item, even a rejected one, occupies the engine: busy is high once it is accepted.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("engine not busy after accepting an item");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (root_p == 10'd0 && root_q == 10'd0 && !same_set && !merged))
    else $error("rejected item reported roots or flags");

  a_merge_distinct: assert property (@(posedge clk) disable iff (rst)
    (done && merged) |-> (!same_set && root_p != root_q))
    else $error("merge reported for a single set");

  a_same_roots: assert property (@(posedge clk) disable iff (rst)
    (done && same_set) |-> (root_p == root_q))
    else $error("same_set with different roots");

endmodule

bind weighted_union_find wuf_checker u_chk (.*);
